/* rtl/core/sem_pkg.sv */
package sem_pkg;

	localparam int MaxWidth   = 1024;
	localparam int MaxHeight  = 1024;
	localparam int AddrW      = $clog2(MaxWidth);
	localparam int CompW      = 8;
	localparam int Comps      = 3;
	localparam int PixW       = CompW * Comps;
	localparam int CfgW       = 11;
	localparam int CfgIdxW    = 2;
	localparam int QueueDepth = 4;
	localparam int QPtrW      = $clog2(QueueDepth);
	localparam int SqW        = 18;
	localparam int RootSteps  = 9;
	localparam int StepW      = 4;

	localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = 2'd1;

	localparam logic [CfgW-1:0] WidthReset  = 11'd640;
	localparam logic [CfgW-1:0] HeightReset = 11'd480;

	typedef logic [PixW-1:0] pix_t;

	typedef struct packed {
		logic          interior;
		logic          frame_last;
		pix_t [8:0]    win;
	} job_t;

	typedef enum logic [1:0] {
		FR_CLEAR,
		FR_IDLE,
		FR_UPDATE
	} front_state_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SQUARE,
		BK_ROOT,
		BK_DONE
	} back_state_t;

	function automatic logic [CompW-1:0] clamp_byte(input logic signed [11:0] s);
		logic [CompW-1:0] res;
		if (s < 0) begin
			res = '0;
		end else if (s > 12'sd255) begin
			res = 8'hFF;
		end else begin
			res = s[CompW-1:0];
		end
		return res;
	endfunction

endpackage

/* rtl/core/sem_front.sv */
module sem_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [sem_pkg::CompW-1:0]     comp0,
	input  logic [sem_pkg::CompW-1:0]     comp1,
	input  logic [sem_pkg::CompW-1:0]     comp2,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sem_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [sem_pkg::CfgW-1:0]      cfg_data,
	output sem_pkg::job_t                 job,
	output logic                          job_push,
	input  logic                          q_room
);

	sem_pkg::front_state_t state_q, state_nxt;

	logic [sem_pkg::AddrW-1:0] clr_idx_q;
	logic [sem_pkg::AddrW-1:0] col_q, row_q;
	logic [sem_pkg::CfgW-1:0]  width_q, height_q;
	logic [sem_pkg::CfgW-1:0]  weff, heff;
	logic                      last_col, last_row, accept;

	sem_pkg::pix_t upper_mem  [sem_pkg::MaxWidth];
	sem_pkg::pix_t middle_mem [sem_pkg::MaxWidth];

	sem_pkg::pix_t             pix_s1, up_rd_s1, mid_rd_s1;
	logic [sem_pkg::AddrW-1:0] addr_s1;
	logic                      emit_s1, interior_s1, last_s1;

	sem_pkg::pix_t win_q [9];
	sem_pkg::pix_t win_nxt [9];

	logic                      mem_we;
	logic [sem_pkg::AddrW-1:0] mem_waddr;
	sem_pkg::pix_t             wr_up, wr_mid;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;

	// effective geometry, out-of-range values pinned to the legal range
	always_comb begin
		weff = width_q;
		if (width_q < 11'd3) weff = 11'd3;
		else if (width_q > sem_pkg::CfgW'(sem_pkg::MaxWidth)) weff = sem_pkg::CfgW'(sem_pkg::MaxWidth);
		heff = height_q;
		if (height_q < 11'd3) heff = 11'd3;
		else if (height_q > sem_pkg::CfgW'(sem_pkg::MaxHeight)) heff = sem_pkg::CfgW'(sem_pkg::MaxHeight);
	end

	assign last_col = {1'b0, col_q} >= weff - 11'd1;
	assign last_row = {1'b0, row_q} >= heff - 11'd1;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			sem_pkg::FR_CLEAR: begin
				if (clr_idx_q == sem_pkg::AddrW'(sem_pkg::MaxWidth - 1)) state_nxt = sem_pkg::FR_IDLE;
			end
			sem_pkg::FR_IDLE: begin
				if (accept) state_nxt = sem_pkg::FR_UPDATE;
			end
			sem_pkg::FR_UPDATE: state_nxt = sem_pkg::FR_IDLE;
			default: state_nxt = sem_pkg::FR_CLEAR;
		endcase
	end

	always_comb begin
		full      = 1'b1;
		mem_we    = 1'b0;
		mem_waddr = clr_idx_q;
		wr_up     = '0;
		wr_mid    = '0;
		job_push  = 1'b0;
		unique case (state_q)
			sem_pkg::FR_CLEAR: begin
				mem_we = 1'b1;
			end
			sem_pkg::FR_IDLE: begin
				full = !q_room;
			end
			sem_pkg::FR_UPDATE: begin
				mem_we    = 1'b1;
				mem_waddr = addr_s1;
				wr_up     = mid_rd_s1;
				wr_mid    = pix_s1;
				job_push  = emit_s1;
			end
			default: ;
		endcase
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			win_nxt[3*i]   = win_q[3*i+1];
			win_nxt[3*i+1] = win_q[3*i+2];
		end
		win_nxt[2] = up_rd_s1;
		win_nxt[5] = mid_rd_s1;
		win_nxt[8] = pix_s1;
	end

	always_comb begin
		job.interior   = interior_s1;
		job.frame_last = last_s1;
		for (int i = 0; i < 9; i++) job.win[i] = win_nxt[i];
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			upper_mem[mem_waddr]  <= wr_up;
			middle_mem[mem_waddr] <= wr_mid;
		end
		if (accept) begin
			up_rd_s1  <= upper_mem[col_q];
			mid_rd_s1 <= middle_mem[col_q];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1      <= {comp2, comp1, comp0};
			addr_s1     <= col_q;
			emit_s1     <= (row_q != '0) && (col_q != '0);
			interior_s1 <= (row_q >= 10'd2) && (col_q >= 10'd2);
			last_s1     <= last_col && last_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sem_pkg::FR_CLEAR;
			clr_idx_q <= '0;
			col_q     <= '0;
			row_q     <= '0;
			width_q   <= sem_pkg::WidthReset;
			height_q  <= sem_pkg::HeightReset;
			for (int i = 0; i < 9; i++) win_q[i] <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == sem_pkg::FR_CLEAR) clr_idx_q <= clr_idx_q + 1'b1;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					sem_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data;
					sem_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			if (state_q == sem_pkg::FR_UPDATE) begin
				for (int i = 0; i < 9; i++) win_q[i] <= win_nxt[i];
			end
		end
	end

endmodule

/* rtl/core/sem_queue.sv */
module sem_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_push,
	input  sem_pkg::job_t in_job,
	output logic          room,
	input  logic          out_pop,
	output sem_pkg::job_t out_job,
	output logic          out_valid
);

	sem_pkg::job_t             mem_q [sem_pkg::QueueDepth];
	logic [sem_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [sem_pkg::QPtrW:0]   cnt_q;
	logic                      do_push, do_pop;

	assign room      = cnt_q < (sem_pkg::QPtrW+1)'(sem_pkg::QueueDepth);
	assign out_valid = cnt_q != '0;
	assign out_job   = mem_q[rd_ptr_q];
	assign do_push   = in_push && room;
	assign do_pop    = out_pop && out_valid;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= in_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

/* rtl/core/sem_back.sv */
module sem_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sem_pkg::job_t             job,
	input  logic                      job_valid,
	output logic                      job_pop,
	output logic                      empty,
	input  logic                      pop,
	output logic [sem_pkg::CompW-1:0] mag0,
	output logic [sem_pkg::CompW-1:0] mag1,
	output logic [sem_pkg::CompW-1:0] mag2,
	output logic                      frame_last
);

	sem_pkg::back_state_t state_q, state_nxt;

	logic [sem_pkg::CompW-1:0] ax_q [sem_pkg::Comps];
	logic [sem_pkg::CompW-1:0] ay_q [sem_pkg::Comps];
	logic [sem_pkg::CompW-1:0] ax_c [sem_pkg::Comps];
	logic [sem_pkg::CompW-1:0] ay_c [sem_pkg::Comps];
	logic [sem_pkg::SqW-1:0]   v_q  [sem_pkg::Comps];
	logic [sem_pkg::SqW-1:0]   r_q  [sem_pkg::Comps];
	logic [sem_pkg::SqW-1:0]   v_nx [sem_pkg::Comps];
	logic [sem_pkg::SqW-1:0]   r_nx [sem_pkg::Comps];
	logic [sem_pkg::SqW-1:0]   bit_c, trial;
	logic [sem_pkg::StepW-1:0] step_q;
	logic                      int_q, last_q;

	// two-entry result buffer, mags then frame_last
	logic [sem_pkg::CompW*sem_pkg::Comps:0] ob_q [2];
	logic [sem_pkg::CompW*sem_pkg::Comps:0] ob_in;
	logic                                   ob_wr_q, ob_rd_q, ob_push, ob_pop;
	logic [1:0]                             ob_cnt_q;

	assign empty = ob_cnt_q == '0;
	assign {frame_last, mag2, mag1, mag0} = ob_q[ob_rd_q];
	assign ob_pop = pop && !empty;

	// sobel sums, clamped
	always_comb begin
		for (int k = 0; k < sem_pkg::Comps; k++) begin
			logic signed [11:0] p [9];
			logic signed [11:0] gx, gy;
			for (int i = 0; i < 9; i++) p[i] = {4'd0, job.win[i][k*sem_pkg::CompW +: sem_pkg::CompW]};
			gx = p[2] - p[0] + 12'sd2 * (p[5] - p[3]) + p[8] - p[6];
			gy = p[6] - p[0] + 12'sd2 * (p[7] - p[1]) + p[8] - p[2];
			ax_c[k] = sem_pkg::clamp_byte(gx);
			ay_c[k] = sem_pkg::clamp_byte(gy);
		end
	end

	// one digit of the integer root per step
	assign bit_c = sem_pkg::SqW'(18'h10000 >> {step_q, 1'b0});
	always_comb begin
		trial = '0;
		for (int k = 0; k < sem_pkg::Comps; k++) begin
			trial = r_q[k] + bit_c;
			if (v_q[k] >= trial) begin
				v_nx[k] = v_q[k] - trial;
				r_nx[k] = (r_q[k] >> 1) + bit_c;
			end else begin
				v_nx[k] = v_q[k];
				r_nx[k] = r_q[k] >> 1;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			sem_pkg::BK_IDLE:   if (job_valid && ob_cnt_q != 2'd2) state_nxt = sem_pkg::BK_SQUARE;
			sem_pkg::BK_SQUARE: state_nxt = sem_pkg::BK_ROOT;
			sem_pkg::BK_ROOT:   if (step_q == sem_pkg::StepW'(sem_pkg::RootSteps - 1)) state_nxt = sem_pkg::BK_DONE;
			sem_pkg::BK_DONE:   state_nxt = sem_pkg::BK_IDLE;
			default:            state_nxt = sem_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		job_pop = (state_q == sem_pkg::BK_IDLE) && job_valid && (ob_cnt_q != 2'd2);
		ob_push = state_q == sem_pkg::BK_DONE;
		ob_in[sem_pkg::CompW*sem_pkg::Comps] = last_q;
		for (int k = 0; k < sem_pkg::Comps; k++) begin
			ob_in[k*sem_pkg::CompW +: sem_pkg::CompW] =
				(r_q[k] > 18'd255) ? 8'hFF : r_q[k][sem_pkg::CompW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			int_q  <= job.interior;
			last_q <= job.frame_last;
			for (int k = 0; k < sem_pkg::Comps; k++) begin
				ax_q[k] <= ax_c[k];
				ay_q[k] <= ay_c[k];
			end
		end
		if (state_q == sem_pkg::BK_SQUARE) begin
			for (int k = 0; k < sem_pkg::Comps; k++) begin
				v_q[k] <= int_q ? (sem_pkg::SqW'(ax_q[k] * ax_q[k]) + sem_pkg::SqW'(ay_q[k] * ay_q[k]))
				                : '0;
				r_q[k] <= '0;
			end
		end else if (state_q == sem_pkg::BK_ROOT) begin
			for (int k = 0; k < sem_pkg::Comps; k++) begin
				v_q[k] <= v_nx[k];
				r_q[k] <= r_nx[k];
			end
		end
		if (ob_push) ob_q[ob_wr_q] <= ob_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sem_pkg::BK_IDLE;
			step_q   <= '0;
			ob_wr_q  <= 1'b0;
			ob_rd_q  <= 1'b0;
			ob_cnt_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == sem_pkg::BK_ROOT) step_q <= step_q + 1'b1;
			else step_q <= '0;
			if (ob_push) ob_wr_q <= !ob_wr_q;
			if (ob_pop)  ob_rd_q <= !ob_rd_q;
			unique case ({ob_push, ob_pop})
				2'b10:   ob_cnt_q <= ob_cnt_q + 1'b1;
				2'b01:   ob_cnt_q <= ob_cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

/* rtl/core/sobel_edge_magnitude_top.sv */
// channel   | handshake                | payload
// pixel in  | push / full              | comp0, comp1, comp2
// result    | empty / pop              | mag0, mag1, mag2, frame_last
// config    | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// in the front a pixel gets a single-port line store read, then a write-back
// in the back a result goes through sums, squares, 9 root steps, then a buffer write
// so results go at the back's pace, one window at a time; first row and column give none
// after reset full stays high while the line stores are zeroed
// a 4-deep job queue and a 2-deep result buffer let each side stall on its own
module sobel_edge_magnitude_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [sem_pkg::CompW-1:0]   comp0,
	input  logic [sem_pkg::CompW-1:0]   comp1,
	input  logic [sem_pkg::CompW-1:0]   comp2,
	output logic                        empty,
	input  logic                        pop,
	output logic [sem_pkg::CompW-1:0]   mag0,
	output logic [sem_pkg::CompW-1:0]   mag1,
	output logic [sem_pkg::CompW-1:0]   mag2,
	output logic                        frame_last,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [sem_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [sem_pkg::CfgW-1:0]    cfg_data
);

	// front to queue
	sem_pkg::job_t f_job, q_job;
	logic          f_push, q_room;
	// queue to back
	logic          q_valid, b_pop;

	// window, counters and line stores
	sem_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.comp0     (comp0),
		.comp1     (comp1),
		.comp2     (comp2),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.job       (f_job),
		.job_push  (f_push),
		.q_room    (q_room)
	);

	// windows waiting for the magnitude unit
	sem_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_push   (f_push),
		.in_job    (f_job),
		.room      (q_room),
		.out_pop   (b_pop),
		.out_job   (q_job),
		.out_valid (q_valid)
	);

	// gradients, squares, iterative root, result buffer
	sem_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job        (q_job),
		.job_valid  (q_valid),
		.job_pop    (b_pop),
		.empty      (empty),
		.pop        (pop),
		.mag0       (mag0),
		.mag1       (mag1),
		.mag2       (mag2),
		.frame_last (frame_last)
	);

	// front is busy for the write-back cycle after every accepted word
	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> full)
		else $error("front accepted a word during write-back");

	// front only issues a window when the queue has room
	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		f_push |-> q_room)
		else $error("job queue overflow");

	// back never pulls a window that is not there
	a_back_pop: assert property (@(posedge clk) disable iff (!arst_n)
		b_pop |-> q_valid)
		else $error("magnitude unit popped an empty queue");

endmodule
